// ===== src/fppk_pkg.sv =====
// Package for the float pixel format packer.
// Holds format codes, the lane result type and the half-float conversion function.
// No dependencies.
package fppk_pkg;

  localparam logic [1:0] FMT_HALF = 2'd0;
  localparam logic [1:0] FMT_2101010 = 2'd1;
  localparam logic [1:0] FMT_8888 = 2'd2;
  localparam logic [1:0] FMT_UNKNOWN = 2'd3;

  localparam logic [1:0] FMT_RESET = FMT_2101010;

  typedef struct packed {
    logic [15:0] half;
    logic [9:0] un10;
    logic [7:0] un8;
    logic [1:0] un2;
  } lane_res_t;

  function automatic logic [15:0] to_half(input logic [31:0] x);
    logic [31:0] b;
    logic [7:0] e;
    logic [22:0] m;
    logic [15:0] h;
    logic [23:0] num;
    logic [4:0] sh;
    logic [23:0] q;
    b = x + 32'h0000_1000;
    e = b[30:23];
    m = b[22:0];
    h = {b[31], 15'd0};
    sh = 5'(8'd125 - e);
    num = 24'h7FF000 + {1'b0, m};
    q = (num >> sh) + 24'd1;
    if (e > 8'd112) begin
      h = h | {1'b0, 5'(e - 8'd112), m[22:13]};
    end
    if (e < 8'd113 && e > 8'd101) begin
      h = h | 16'(q >> 1);
    end
    if (e > 8'd143) begin
      h = h | 16'h7FFF;
    end
    return h;
  endfunction

endpackage

// ===== src/fppk_unorm.sv =====
// Unorm scaling of one fp32 component: saturate, multiply by 2^w-1 with
// round-to-nearest-even, floor. Two stages (multiply, then round/shift).
// Depends on fppk_pkg.
module fppk_unorm
  import fppk_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] x,
  output logic [9:0]  un10,
  output logic [7:0]  un8,
  output logic [1:0]  un2
);

  logic        sat_nxt;
  logic        zero_nxt;
  logic [23:0] sig;
  logic [7:0]  e;
  logic [33:0] p10_nxt;
  logic [31:0] p8_nxt;
  logic [25:0] p2_nxt;
  logic [33:0] p10_r;
  logic [31:0] p8_r;
  logic [25:0] p2_r;
  logic [7:0]  sh_r;
  logic        sat_r;
  logic        zero_r;
  logic [9:0]  u10;
  logic [7:0]  u8;
  logic [1:0]  u2;

  // value = sig * 2^(e-150); 0 < v < 1 means e < 127
  always_comb begin
    e = x[30:23];
    sig = (e == 8'd0) ? {1'b0, x[22:0]} : {1'b1, x[22:0]};
    zero_nxt = x[31] || (x[30:0] == 31'd0) || (e == 8'hFF && x[22:0] != 23'd0);
    sat_nxt = !zero_nxt && (e >= 8'd127);
    p10_nxt = 34'(sig) * 34'd1023;
    p8_nxt = 32'(sig) * 32'd255;
    p2_nxt = 26'(sig) * 26'd3;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p10_r <= p10_nxt;
      p8_r <= p8_nxt;
      p2_r <= p2_nxt;
      sh_r <= (e == 8'd0) ? 8'd149 : 8'd150 - e;
      sat_r <= sat_nxt;
      zero_r <= zero_nxt;
    end
  end

  // round product to 24 significant bits (RNE) then floor of p * 2^-sh
  function automatic logic [9:0] fl(input logic [33:0] p, input logic [7:0] sh);
    logic [5:0]  msb;
    logic [5:0]  drop;
    logic [34:0] r;
    logic [33:0] mask;
    logic [33:0] half;
    logic [33:0] low;
    logic [34:0] v;
    msb = 6'd0;
    for (int i = 0; i < 34; i++) begin
      if (p[i]) msb = 6'(i);
    end
    drop = (msb > 6'd23) ? msb - 6'd23 : 6'd0;
    mask = (34'd1 << drop) - 34'd1;
    half = (drop == 6'd0) ? 34'd0 : (34'd1 << (drop - 6'd1));
    low = p & mask;
    r = {1'b0, p & ~mask};
    if (drop != 6'd0 && (low > half || (low == half && p[drop]))) begin
      r = r + (35'd1 << drop);
    end
    v = (sh > 8'd34) ? 35'd0 : (r >> sh);
    return v[9:0];
  endfunction

  always_comb begin
    u10 = fl(p10_r, sh_r);
    u8 = 8'(fl({2'b0, p8_r}, sh_r));
    u2 = 2'(fl({8'b0, p2_r}, sh_r));
    un10 = zero_r ? 10'd0 : (sat_r ? 10'h3FF : u10);
    un8 = zero_r ? 8'd0 : (sat_r ? 8'hFF : u8);
    un2 = zero_r ? 2'd0 : (sat_r ? 2'h3 : u2);
  end

endmodule

// ===== src/fppk_lane.sv =====
// One component lane: half-float conversion and unorm scaling.
// Registers the half result alongside the unorm pipeline.
// Depends on fppk_pkg and fppk_unorm.
module fppk_lane
  import fppk_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] x,
  output lane_res_t   res
);

  logic [15:0] half_r;
  logic [9:0]  un10;
  logic [7:0]  un8;
  logic [1:0]  un2;

  always_ff @(posedge clk) begin
    if (en) begin
      half_r <= to_half(x);
    end
  end

  fppk_unorm u_unorm (
    .clk  (clk),
    .en   (en),
    .x    (x),
    .un10 (un10),
    .un8  (un8),
    .un2  (un2)
  );

  assign res = '{half: half_r, un10: un10, un8: un8, un2: un2};

endmodule

// ===== src/float_pixel_format_packer_unit.sv =====
// Float pixel format packer: four fp32 components in, one packed pixel out.
// Holds the format register, four lanes and the merge stage.
// Depends on fppk_pkg and fppk_lane.
//
// Usage:
//   Input channel in_valid/in_ready carries alpha, red, green and blue as fp32
//   bit patterns. Output channel out_valid/out_ready carries the 64-bit pixel.
//   Four lanes convert the components in one stage; the merge stage packs the
//   pixel by the format register into the output register.
//   An input transfer is registered in the lanes, then in the output stage.
//   Throughput: one pixel per cycle while out_ready is high; the two stages
//   advance separately. When the receiver stalls, the pipeline holds and
//   in_ready drops once both stages are full.
//   Reset clears both stages and sets the format to ABGR2101010.
//   The format register sits at address 0 of the APB-style port; write only
//   while the pipeline is empty. Format 3 gives an all-ones pixel.
module float_pixel_format_packer_unit
  import fppk_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_alpha_bits,
  input  logic [31:0] in_red_bits,
  input  logic [31:0] in_green_bits,
  input  logic [31:0] in_blue_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_packed_pixel,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [0:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [1:0]  fmt_r;
  logic        s1_vld_r;
  logic        s2_vld_r;
  logic        adv;
  logic [63:0] pix_nxt;
  logic [63:0] pix_r;
  lane_res_t   ra;
  lane_res_t   rr;
  lane_res_t   rg;
  lane_res_t   rb;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == 1'b0) ? {30'd0, fmt_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 1'b0) begin
      fmt_r <= cfg_pwdata[1:0];
    end
  end

  assign adv = !s2_vld_r || out_ready || !s1_vld_r;
  assign in_ready = !s1_vld_r || !s2_vld_r || out_ready;

  logic s1_en;
  logic s2_en;
  assign s2_en = !s2_vld_r || out_ready;
  assign s1_en = !s1_vld_r || s2_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      if (s1_en) s1_vld_r <= in_valid;
      if (s2_en) s2_vld_r <= s1_vld_r;
    end
  end

  fppk_lane u_a (.clk(clk), .en(s1_en), .x(in_alpha_bits), .res(ra));
  fppk_lane u_r (.clk(clk), .en(s1_en), .x(in_red_bits),   .res(rr));
  fppk_lane u_g (.clk(clk), .en(s1_en), .x(in_green_bits), .res(rg));
  fppk_lane u_b (.clk(clk), .en(s1_en), .x(in_blue_bits),  .res(rb));

  always_comb begin
    unique case (fmt_r)
      FMT_HALF:    pix_nxt = {ra.half, rb.half, rg.half, rr.half};
      FMT_2101010: pix_nxt = {32'd0, ra.un2, rb.un10, rg.un10, rr.un10};
      FMT_8888:    pix_nxt = {32'd0, ra.un8, rr.un8, rg.un8, rb.un8};
      default:     pix_nxt = '1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (s2_en && adv) begin
      pix_r <= pix_nxt;
    end
  end

  assign out_valid = s2_vld_r;
  assign out_packed_pixel = pix_r;

endmodule
